// ===== hdl/mtk_pkg.sv =====
// Package for the Morse text keyer: widths, reset values, register indexes,
// element codes, the queue entry layout and the character-to-pattern function.
// Depends on nothing; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package mtk_pkg;

    localparam int CHAR_W  = 8;
    localparam int TICK_W  = 16;
    localparam int INDEX_W = 8;

    localparam int QUEUE_DEPTH_DEFAULT = 256;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam logic [TICK_W-1:0] DOT_TICKS_RESET  = 16'd500;
    localparam logic [TICK_W-1:0] DASH_TICKS_RESET = 16'd1200;
    localparam logic [TICK_W-1:0] GAP_TICKS_RESET  = 16'd1000;
    localparam logic [TICK_W-1:0] TAIL_TICKS_RESET = 16'd200;

    localparam logic [INDEX_W-1:0] CFG_DOT_TICKS       = 8'd0;
    localparam logic [INDEX_W-1:0] CFG_DASH_TICKS      = 8'd1;
    localparam logic [INDEX_W-1:0] CFG_GAP_TICKS       = 8'd2;
    localparam logic [INDEX_W-1:0] CFG_DARK_TAIL_TICKS = 8'd3;

    localparam logic       KIND_CHAR      = 1'b0;
    localparam logic [2:0] MAX_MARKS      = 3'd5;
    localparam logic [2:0] IDX_GAP_PHASE  = 3'd7;

    typedef enum logic [1:0] {
        ELEM_NONE = 2'd0,
        ELEM_DOT  = 2'd1,
        ELEM_DASH = 2'd2,
        ELEM_GAP  = 2'd3
    } elem_t;

    // One queued character: gap count, marks (bit n set means element n is a
    // dash) and the number of marks.
    typedef struct packed {
        logic [1:0] gaps;
        logic [4:0] marks;
        logic [2:0] len;
    } entry_t;

    typedef struct packed {
        logic   ok;
        entry_t entry;
    } pattern_t;

    function automatic pattern_t char_pattern(input logic [CHAR_W-1:0] c);
        pattern_t p;
        p.ok         = 1'b1;
        p.entry.gaps = 2'd1;
        p.entry.len  = 3'd0;
        p.entry.marks = 5'b00000;
        case (c)
            8'h61: begin p.entry.len = 3'd2; p.entry.marks = 5'b00010; end
            8'h62: begin p.entry.len = 3'd4; p.entry.marks = 5'b00001; end
            8'h63: begin p.entry.len = 3'd4; p.entry.marks = 5'b00101; end
            8'h64: begin p.entry.len = 3'd3; p.entry.marks = 5'b00001; end
            8'h65: begin p.entry.len = 3'd1; p.entry.marks = 5'b00000; end
            8'h66: begin p.entry.len = 3'd4; p.entry.marks = 5'b00100; end
            8'h67: begin p.entry.len = 3'd3; p.entry.marks = 5'b00011; end
            8'h68: begin p.entry.len = 3'd4; p.entry.marks = 5'b00000; end
            8'h69: begin p.entry.len = 3'd2; p.entry.marks = 5'b00000; end
            8'h6a: begin p.entry.len = 3'd4; p.entry.marks = 5'b01110; end
            8'h6b: begin p.entry.len = 3'd3; p.entry.marks = 5'b00101; end
            8'h6c: begin p.entry.len = 3'd4; p.entry.marks = 5'b00010; end
            8'h6d: begin p.entry.len = 3'd2; p.entry.marks = 5'b00011; end
            8'h6e: begin p.entry.len = 3'd2; p.entry.marks = 5'b00001; end
            8'h6f: begin p.entry.len = 3'd3; p.entry.marks = 5'b00111; end
            8'h70: begin p.entry.len = 3'd4; p.entry.marks = 5'b00110; end
            8'h71: begin p.entry.len = 3'd4; p.entry.marks = 5'b01011; end
            8'h72: begin p.entry.len = 3'd3; p.entry.marks = 5'b00010; end
            8'h73: begin p.entry.len = 3'd3; p.entry.marks = 5'b00000; end
            8'h74: begin p.entry.len = 3'd1; p.entry.marks = 5'b00001; end
            8'h75: begin p.entry.len = 3'd3; p.entry.marks = 5'b00100; end
            8'h76: begin p.entry.len = 3'd4; p.entry.marks = 5'b01000; end
            8'h77: begin p.entry.len = 3'd3; p.entry.marks = 5'b00110; end
            8'h78: begin p.entry.len = 3'd4; p.entry.marks = 5'b01001; end
            8'h79: begin p.entry.len = 3'd4; p.entry.marks = 5'b01101; end
            8'h7a: begin p.entry.len = 3'd4; p.entry.marks = 5'b00011; end
            8'h30: begin p.entry.len = 3'd5; p.entry.marks = 5'b11111; end
            8'h31: begin p.entry.len = 3'd5; p.entry.marks = 5'b11110; end
            8'h32: begin p.entry.len = 3'd5; p.entry.marks = 5'b11100; end
            8'h33: begin p.entry.len = 3'd5; p.entry.marks = 5'b11000; end
            8'h34: begin p.entry.len = 3'd5; p.entry.marks = 5'b10000; end
            8'h35: begin p.entry.len = 3'd5; p.entry.marks = 5'b00000; end
            8'h36: begin p.entry.len = 3'd5; p.entry.marks = 5'b00001; end
            8'h37: begin p.entry.len = 3'd5; p.entry.marks = 5'b00011; end
            8'h38: begin p.entry.len = 3'd5; p.entry.marks = 5'b00111; end
            8'h39: begin p.entry.len = 3'd5; p.entry.marks = 5'b01111; end
            8'h20: begin p.entry.gaps = 2'd3; end
            default: begin p.ok = 1'b0; end
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/mtk_if.sv =====
// Valid/ready channel interfaces of the Morse text keyer: input items,
// result items and register writes. Depends on mtk_pkg for field widths.
`timescale 1ns / 1ps

interface mtk_item_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [mtk_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, kind, char_code, input ready);
    modport sink (input valid, kind, char_code, output ready);
endinterface

interface mtk_result_if;
    logic valid;
    logic ready;
    logic lamp;
    logic busy_res;
    logic dropped;

    modport source (output valid, lamp, busy_res, dropped, input ready);
    modport sink (input valid, lamp, busy_res, dropped, output ready);
endinterface

interface mtk_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mtk_pkg::INDEX_W-1:0] index;
    logic [mtk_pkg::TICK_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/morse_text_keyer_core.sv =====
// Morse text keyer core: character queue memory, element sequencer, countdown
// and lamp control with a registered result stage.
// Depends on mtk_pkg and the channel interfaces in mtk_if.sv.
`timescale 1ns / 1ps

// The keyer takes one request per clock cycle, characters and timer ticks
// alike, unless an untaken result stalls it, and delivers one result for each
// request in the cycle after it is accepted; a waiting result does not block
// the next request as long as the result is taken in the same cycle. The
// pattern of the character at the head of the queue is read from the queue
// memory ahead of its use, with the write port bypassed onto the read port,
// so no clearing pass is needed after reset. Register writes are accepted in
// every cycle and should only be made while the keyer is idle.
module morse_text_keyer_core #(
    parameter int QUEUE_DEPTH = mtk_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int COUNT_WIDTH = mtk_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    mtk_item_if.sink            item,
    mtk_result_if.source        result,
    mtk_cfg_if.sink             cfg
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (COUNT_WIDTH > mtk_pkg::TICK_W) ? COUNT_WIDTH : mtk_pkg::TICK_W;

    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(QUEUE_DEPTH);

    logic [mtk_pkg::TICK_W-1:0] dot_ticks_reg;
    logic [mtk_pkg::TICK_W-1:0] dash_ticks_reg;
    logic [mtk_pkg::TICK_W-1:0] gap_ticks_reg;
    logic [mtk_pkg::TICK_W-1:0] tail_ticks_reg;

    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [2:0]             idx_reg, idx_next;
    logic [1:0]             gaps_left_reg, gaps_left_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    mtk_pkg::elem_t         elem_reg, elem_next;
    logic                   lead_reg, lead_next;
    logic                   lamp_reg, lamp_next;

    logic                   res_valid_reg;
    logic                   res_lamp_reg;
    logic                   res_busy_reg;
    logic                   res_dropped_reg;

    mtk_pkg::entry_t        queue_mem [QUEUE_DEPTH];
    mtk_pkg::entry_t        head_entry_reg;

    logic                   accept;
    logic                   mem_we;
    mtk_pkg::entry_t        mem_wdata;
    mtk_pkg::pattern_t      pattern;
    logic                   dropped;
    logic                   busy;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic [1:0]             gaps_now;
    logic [1:0]             gaps_dec;
    logic                   is_dash;
    logic [COUNT_WIDTH-1:0] dot_load;
    logic [COUNT_WIDTH-1:0] dash_load;
    logic [COUNT_WIDTH-1:0] gap_load;

    assign accept     = item.valid && item.ready;
    assign item.ready = !res_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid    = res_valid_reg;
    assign result.lamp     = res_lamp_reg;
    assign result.busy_res = res_busy_reg;
    assign result.dropped  = res_dropped_reg;

    assign dot_load  = COUNT_WIDTH'(dot_ticks_reg);
    assign dash_load = COUNT_WIDTH'(dash_ticks_reg);
    assign gap_load  = COUNT_WIDTH'(gap_ticks_reg);

    assign pattern   = mtk_pkg::char_pattern(item.char_code);
    assign mem_wdata = pattern.entry;
    assign count_dec = (count_reg != '0) ? count_reg - 1'b1 : '0;
    assign is_dash   = head_entry_reg.marks[idx_reg];
    assign gaps_now  = (idx_reg != mtk_pkg::IDX_GAP_PHASE) ? head_entry_reg.gaps : gaps_left_reg;
    assign gaps_dec  = gaps_now - 2'd1;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        gaps_left_next = gaps_left_reg;
        count_next     = count_reg;
        elem_next      = elem_reg;
        lead_next      = lead_reg;
        lamp_next      = lamp_reg;
        mem_we         = 1'b0;
        dropped        = 1'b0;
        if (accept)
        begin
            if (item.kind == mtk_pkg::KIND_CHAR)
            begin
                if (pattern.ok)
                begin
                    if (fill_reg == FILL_FULL)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            else
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    if (fill_reg == '0)
                    begin
                        elem_next = mtk_pkg::ELEM_NONE;
                    end
                    else if (lead_reg)
                    begin
                        lead_next  = 1'b0;
                        elem_next  = mtk_pkg::ELEM_GAP;
                        count_next = gap_load;
                    end
                    else if (idx_reg < head_entry_reg.len && idx_reg < mtk_pkg::MAX_MARKS)
                    begin
                        idx_next   = idx_reg + 3'd1;
                        elem_next  = is_dash ? mtk_pkg::ELEM_DASH : mtk_pkg::ELEM_DOT;
                        count_next = is_dash ? dash_load : dot_load;
                    end
                    else
                    begin
                        idx_next       = mtk_pkg::IDX_GAP_PHASE;
                        gaps_left_next = gaps_dec;
                        elem_next      = mtk_pkg::ELEM_GAP;
                        count_next     = gap_load;
                        if (gaps_dec == 2'd0)
                        begin
                            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                            fill_next = fill_reg - 1'b1;
                            idx_next  = 3'd0;
                        end
                    end
                end
                if (elem_next == mtk_pkg::ELEM_DOT || elem_next == mtk_pkg::ELEM_DASH)
                begin
                    lamp_next = CMP_W'(count_next) > CMP_W'(tail_ticks_reg);
                end
                else if (elem_next == mtk_pkg::ELEM_NONE)
                begin
                    lamp_next = 1'b0;
                end
            end
        end
    end

    assign busy = (fill_next != '0) || (elem_next != mtk_pkg::ELEM_NONE);

    // Queue memory: write at the tail, read the next head with write bypass.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[tail_reg] <= mem_wdata;
        end
        if (mem_we && tail_reg == head_next)
        begin
            head_entry_reg <= mem_wdata;
        end
        else
        begin
            head_entry_reg <= queue_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= 3'd0;
            gaps_left_reg <= 2'd0;
            count_reg     <= '0;
            elem_reg      <= mtk_pkg::ELEM_NONE;
            lead_reg      <= 1'b1;
            lamp_reg      <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            gaps_left_reg <= gaps_left_next;
            count_reg     <= count_next;
            elem_reg      <= elem_next;
            lead_reg      <= lead_next;
            lamp_reg      <= lamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_ticks_reg  <= mtk_pkg::DOT_TICKS_RESET;
            dash_ticks_reg <= mtk_pkg::DASH_TICKS_RESET;
            gap_ticks_reg  <= mtk_pkg::GAP_TICKS_RESET;
            tail_ticks_reg <= mtk_pkg::TAIL_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mtk_pkg::CFG_DOT_TICKS:       dot_ticks_reg  <= cfg.data;
                mtk_pkg::CFG_DASH_TICKS:      dash_ticks_reg <= cfg.data;
                mtk_pkg::CFG_GAP_TICKS:       gap_ticks_reg  <= cfg.data;
                mtk_pkg::CFG_DARK_TAIL_TICKS: tail_ticks_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_lamp_reg    <= lamp_next;
            res_busy_reg    <= busy;
            res_dropped_reg <= dropped;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("queue fill count exceeds the queue depth");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.dropped |-> fill_reg == FILL_FULL)
        else $error("character dropped while the queue had room");

    a_lamp_needs_element: assert property (@(posedge clk) disable iff (!rst_n)
        lamp_reg |-> elem_reg != mtk_pkg::ELEM_NONE)
        else $error("lamp lit with no element playing");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        elem_reg == mtk_pkg::ELEM_NONE |-> count_reg == '0)
        else $error("countdown running while idle");

endmodule
